@@ design/mlfq_process_scheduler_top_macros.svh @@
// assertion macros for the scheduler
`ifndef MLFQ_PROCESS_SCHEDULER_TOP_MACROS_SVH
`define MLFQ_PROCESS_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MLFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLFQ_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLFQ_ASSERT(label, prop, msg)
`define MLFQ_ASSERT_NORST(label, prop, msg)
`endif
`endif

@@ design/mlfq_pkg.sv @@
// types and constants shared by the scheduler files
package mlfq_pkg;
  localparam int DEF_NUM_ENTRIES = 64;
  localparam int DEF_NUM_CPUS    = 8;
  localparam int DEF_NUM_LEVELS  = 3;
  localparam int LW = 2;

  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_SELECT  = 3'd1;
  localparam logic [2:0] FN_YIELD   = 3'd2;
  localparam logic [2:0] FN_WAKEUP  = 3'd3;
  localparam logic [2:0] FN_QUERY   = 3'd4;
  localparam logic [2:0] FN_ADMIT   = 3'd5;
  localparam logic [2:0] FN_BLOCK   = 3'd6;

  localparam logic [1:0] REG_AGING  = 2'd0;
  localparam logic [1:0] REG_SLICE0 = 2'd1;
  localparam logic [1:0] REG_SLICE1 = 2'd2;
  localparam logic [1:0] REG_SLICE2 = 2'd3;

  localparam logic [15:0] RST_AGING  = 16'd30;
  localparam logic [15:0] RST_SLICE0 = 16'd2;
  localparam logic [15:0] RST_SLICE1 = 16'd4;
  localparam logic [15:0] RST_SLICE2 = 16'd8;

  typedef struct packed {
    logic [2:0] func;
    logic [5:0] proc_index;
    logic [2:0] cpu_index;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] chosen_index;
    logic       preempt;
    logic [1:0] level_after;
  } out_t;

  typedef struct packed {
    logic          run;
    logic [LW-1:0] lvl;
    logic [15:0]   slice;
    logic [31:0]   stamp;
  } entry_t;
endpackage

@@ design/mlfq_cell.sv @@
// one process entry cell of the rotating ring
module mlfq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  mlfq_pkg::entry_t din,
  output mlfq_pkg::entry_t dout
);
  import mlfq_pkg::*;

  entry_t ent_r;

  // take the neighbor's entry on each ring step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (shift_en) begin
      ent_r <= din;
    end
  end

  assign dout = ent_r;
endmodule

@@ design/mlfq_process_scheduler_top.sv @@
// multilevel feedback queue scheduler: entry ring, sequencer and result register
// Tick/yield/wakeup/admit/block: ring seek to the process entry, then update it.
// Select: seek to cursor, full ring scan, seek to winner.
// Preempt query: seek, then full ring scan unless the slice is used up.
// One item at a time; in seek/scan the ring rotates one entry per cycle past a single head cell.
// Reset (synchronous, active low) clears all entries, time, cursors and loads register defaults.
module mlfq_process_scheduler_top #(
  parameter int NUM_ENTRIES = mlfq_pkg::DEF_NUM_ENTRIES,
  parameter int NUM_CPUS    = mlfq_pkg::DEF_NUM_CPUS,
  parameter int NUM_LEVELS  = mlfq_pkg::DEF_NUM_LEVELS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mlfq_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mlfq_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  `include "mlfq_process_scheduler_top_macros.svh"
  import mlfq_pkg::*;

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_ENTRIES - 1);
  localparam logic [LW-1:0] BOTTOM = LW'(NUM_LEVELS - 1);
  localparam logic [LW-1:0] NO_LVL = LW'(NUM_LEVELS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEEK  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_QSCAN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state_r;
  logic [15:0]   thr_r, s0_r, s1_r, s2_r;
  logic [31:0]   time_r;
  logic [IW-1:0] cursors_r [NUM_CPUS];
  logic [IW-1:0] ptr_r, target_r, cnt_r, best_r;
  logic [LW-1:0] best_lvl_r, q_lvl_r;
  logic          found_r, claim_r;
  logic [2:0]    func_r;
  logic [CW-1:0] ci_r;
  out_t          res_r, out_r;
  logic          out_valid_r;

  entry_t cell_q [NUM_ENTRIES];
  entry_t cell_d [NUM_ENTRIES];
  entry_t head, head_nxt;
  logic   rot, hit;
  logic [LW-1:0] op_lvl;
  logic [CW-1:0] ci_mod;
  logic   scan_take;

  function automatic logic [15:0] grant(input logic [LW-1:0] l, input logic [15:0] a,
                                        input logic [15:0] b, input logic [15:0] c);
    logic [15:0] g;
    if (l == LW'(0)) g = a;
    else if (l == LW'(1)) g = b;
    else g = c;
    return g;
  endfunction

  // ring of entry cells
  genvar k;
  generate
    for (k = 0; k < NUM_ENTRIES; k++) begin : g_cell
      if (k == NUM_ENTRIES - 1) begin : g_tail
        assign cell_d[k] = head_nxt;
      end else begin : g_mid
        assign cell_d[k] = cell_q[k+1];
      end
      mlfq_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(rot), .din(cell_d[k]), .dout(cell_q[k])
      );
    end
  endgenerate

  assign head = cell_q[0];
  assign hit  = (ptr_r == target_r);

  // cpu index folded into range
  always_comb begin
    logic [2:0] v;
    v = in_data.cpu_index;
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= NUM_CPUS) v = 3'(32'(v) - NUM_CPUS);
    end
    ci_mod = CW'(v);
  end

  // head entry update
  always_comb begin
    logic [LW-1:0] l;
    head_nxt = head;
    op_lvl   = head.lvl;
    l = (head.lvl > BOTTOM) ? BOTTOM : head.lvl;
    if (state_r == S_SCAN) begin
      if (head.run && ((time_r - head.stamp) >= {16'd0, thr_r}) && head.lvl != LW'(0)) begin
        head_nxt.lvl   = head.lvl - LW'(1);
        head_nxt.slice = grant(head.lvl - LW'(1), s0_r, s1_r, s2_r);
        head_nxt.stamp = time_r;
      end
    end else if (state_r == S_SEEK && hit) begin
      unique case (func_r)
        FN_TICK: begin
          if (head.slice != 16'd0) head_nxt.slice = head.slice - 16'd1;
        end
        FN_SELECT: begin
          if (claim_r) head_nxt.run = 1'b0;
        end
        FN_YIELD: begin
          if (head.slice == 16'd0) begin
            if (l < BOTTOM) l = l + LW'(1);
            head_nxt.slice = grant(l, s0_r, s1_r, s2_r);
          end
          head_nxt.lvl = l; head_nxt.stamp = time_r; head_nxt.run = 1'b1;
          op_lvl = l;
        end
        FN_WAKEUP: begin
          if (l > LW'(0)) l = l - LW'(1);
          head_nxt.lvl = l; head_nxt.slice = grant(l, s0_r, s1_r, s2_r);
          head_nxt.stamp = time_r; head_nxt.run = 1'b1;
          op_lvl = l;
        end
        FN_ADMIT: begin
          head_nxt.lvl = LW'(0); head_nxt.slice = s0_r;
          head_nxt.stamp = time_r; head_nxt.run = 1'b1;
          op_lvl = LW'(0);
        end
        FN_BLOCK: head_nxt.run = 1'b0;
        default: ;
      endcase
    end
  end

  assign scan_take = head_nxt.run && (head_nxt.lvl < best_lvl_r);
  assign rot = (state_r == S_SEEK &&
                (!hit || !((func_r == FN_SELECT && !claim_r) || func_r == FN_QUERY))) ||
               state_r == S_SCAN || state_r == S_QSCAN;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= RST_AGING; s0_r <= RST_SLICE0; s1_r <= RST_SLICE1; s2_r <= RST_SLICE2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AGING:  thr_r <= cfg_data;
        REG_SLICE0: s0_r  <= cfg_data;
        REG_SLICE1: s1_r  <= cfg_data;
        REG_SLICE2: s2_r  <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; time_r <= '0; ptr_r <= '0; out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CPUS; i++) cursors_r[i] <= '0;
    end else begin
      if (rot) ptr_r <= (ptr_r == LAST) ? '0 : ptr_r + IW'(1);
      // result taken while no new one is loaded
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= in_data.func; ci_r <= ci_mod; claim_r <= 1'b0;
            res_r <= '0;
            if (in_data.func == FN_SELECT) target_r <= cursors_r[ci_mod];
            else target_r <= IW'(in_data.proc_index);
            if (in_data.func == FN_TICK) time_r <= time_r + 32'd1;
            if (in_data.func == FN_SELECT) begin
              state_r <= S_SEEK;
            end else if (in_data.func <= FN_BLOCK && 32'(in_data.proc_index) < NUM_ENTRIES) begin
              state_r <= S_SEEK;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SEEK: begin
          if (hit) begin
            if (func_r == FN_SELECT) begin
              if (!claim_r) begin
                state_r <= S_SCAN; cnt_r <= '0; best_lvl_r <= NO_LVL; found_r <= 1'b0;
              end else begin
                cursors_r[ci_r] <= (ptr_r == LAST) ? '0 : ptr_r + IW'(1);
                res_r.found <= 1'b1; res_r.chosen_index <= 6'(ptr_r);
                res_r.level_after <= head.lvl; state_r <= S_DONE;
              end
            end else if (func_r == FN_QUERY) begin
              res_r.level_after <= head.lvl; q_lvl_r <= head.lvl; cnt_r <= '0;
              if (head.slice == 16'd0) begin
                res_r.preempt <= 1'b1; state_r <= S_DONE;
              end else begin
                state_r <= S_QSCAN;
              end
            end else begin
              res_r.level_after <= op_lvl; state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + IW'(1);
          if (scan_take) begin
            best_lvl_r <= head_nxt.lvl; best_r <= ptr_r; found_r <= 1'b1;
          end
          if (cnt_r == LAST) begin
            if (scan_take || found_r) begin
              target_r <= scan_take ? ptr_r : best_r; claim_r <= 1'b1; state_r <= S_SEEK;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_QSCAN: begin
          cnt_r <= cnt_r + IW'(1);
          if (head.run && head.lvl < q_lvl_r) res_r.preempt <= 1'b1;
          if (cnt_r == LAST) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r <= res_r; out_valid_r <= 1'b1; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MLFQ_ASSERT(a_ptr_range, ptr_r <= LAST, "ring pointer out of range")
  `MLFQ_ASSERT(a_done_load, (state_r == S_DONE && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE), "result not loaded")
  `MLFQ_ASSERT(a_seek_target, (state_r == S_SEEK) |-> (target_r <= LAST), "seek target out of range")
  `MLFQ_ASSERT_NORST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset did not idle")
endmodule
